// ===== rtl/core/pfts_pkg.sv =====
// types and constants shared by the thread scheduler modules
`timescale 1ns / 1ps
`default_nettype none
package pfts_pkg;

    // command codes
    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_RESUME   = 3'd1,
        CMD_URESUME  = 3'd2,
        CMD_SUSPEND  = 3'd3,
        CMD_KILL     = 3'd4,
        CMD_YIELD    = 3'd5,
        CMD_SETPRIO  = 3'd6,
        CMD_RESCHED  = 3'd7
    } cmd_t;

    // per-slot thread state
    typedef enum logic [1:0] {
        TS_FREE = 2'd0,
        TS_RUN  = 2'd1,
        TS_SUSP = 2'd2,
        TS_DEAD = 2'd3
    } tstate_t;

    // result status codes
    typedef enum logic [1:0] {
        RS_DONE  = 2'd0,
        RS_FULL  = 2'd1,
        RS_NOCHG = 2'd2
    } rstat_t;

    localparam int LVL_W     = 6;
    localparam int MAIN_SLOT = 0;
    localparam int MAIN_PRIO = 5;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    // per-slot attributes held in the thread table
    typedef struct packed {
        tstate_t            st;
        logic [LVL_W-1:0]   lvl;
        logic               usr;
        logic               dmn;
    } attr_t;

    // sequencer states
    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_DISPATCH,
        SQ_SCAN_RD,
        SQ_SCAN_CHK,
        SQ_ATTR_RD,
        SQ_DECIDE,
        SQ_UL_INIT,
        SQ_UL_CHK,
        SQ_UL_NXT,
        SQ_AFTER_UL,
        SQ_SET_LVL,
        SQ_AP_RD,
        SQ_AP_DO,
        SQ_Y_NEXT,
        SQ_PICK,
        SQ_FINISH
    } seq_t;

endpackage
`default_nettype wire

// ===== rtl/core/pfts_ttab.sv =====
// thread table: per-slot attribute memory with valid bits and queue link memory
`timescale 1ns / 1ps
`default_nettype none
module pfts_ttab
    import pfts_pkg::*;
#(
    parameter int THREAD_SLOTS = 32,
    parameter int MAIN_LVL     = 5,
    parameter int SW           = 5
)(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          a_we,
    input  wire logic [SW-1:0] a_waddr,
    input  wire attr_t         a_wdata,
    input  wire logic [SW-1:0] a_raddr,
    output attr_t              a_rdata,
    input  wire logic          n_we,
    input  wire logic [SW-1:0] n_waddr,
    input  wire logic [SW-1:0] n_wdata,
    input  wire logic [SW-1:0] n_raddr,
    output logic [SW-1:0]      n_rdata
);

    attr_t             attr_mem [THREAD_SLOTS];
    logic [SW-1:0]     next_mem [THREAD_SLOTS];
    logic [THREAD_SLOTS-1:0] vld_reg;
    attr_t             attr_q;
    logic              vld_q;
    logic [SW-1:0]     raddr_q;
    attr_t             rst_attr;

    // attribute memory
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            attr_mem[a_waddr] <= a_wdata;
        end
        attr_q  <= attr_mem[a_raddr];
        raddr_q <= a_raddr;
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vld_q   <= 1'b0;
        end
        else
        begin
            if (a_we)
            begin
                vld_reg[a_waddr] <= 1'b1;
            end
            vld_q <= vld_reg[a_raddr];
        end
    end

    // link memory, undefined until written
    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            next_mem[n_waddr] <= n_wdata;
        end
        n_rdata <= next_mem[n_raddr];
    end

    // entries never written read as their reset value
    always_comb
    begin
        rst_attr.usr = 1'b0;
        rst_attr.dmn = 1'b0;
        if (raddr_q == SW'(MAIN_SLOT))
        begin
            rst_attr.st  = TS_RUN;
            rst_attr.lvl = LVL_W'(MAIN_LVL);
        end
        else
        begin
            rst_attr.st  = TS_FREE;
            rst_attr.lvl = LVL_W'(1);
        end
    end

    assign a_rdata = vld_q ? attr_q : rst_attr;

endmodule
`default_nettype wire

// ===== rtl/core/priority_fifo_thread_scheduler_core.sv =====
// Sequencing: start reads and checks one slot at a time; unlink reads and steps one queue
// entry at a time; reschedule scans one priority level per cycle.
// Throughput: one command at a time; the sequencer and the one-read-port thread table
// limit it. A finished result waits in the output register while a new one is taken.
// Reset: asynchronous active low; slot 0 running at level 5, all other slots free.
`timescale 1ns / 1ps
`default_nettype none
module priority_fifo_thread_scheduler_core
    import pfts_pkg::*;
#(
    parameter int THREAD_SLOTS    = 32,
    parameter int PRIORITY_LEVELS = 10
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // command[2:0], slot[7:3], priority_req[11:8], is_daemon[12], zero pad
    input  wire logic [IN_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // status[1:0], assigned_slot[6:2], running_slot[11:7], switched[12],
    // resched_pending[13], idle[14], all_done[15]
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int SW       = $clog2(THREAD_SLOTS);
    localparam int CW       = $clog2(THREAD_SLOTS + 1);
    localparam int QW       = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int MAIN_LVL = (MAIN_PRIO < PRIORITY_LEVELS) ? MAIN_PRIO : PRIORITY_LEVELS;

    seq_t              state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [SW-1:0]     s_reg, s_next;
    logic              sok_reg, sok_next;
    logic [LVL_W-1:0]  prio_reg, prio_next;
    logic              dmn_reg, dmn_next;
    logic [CW-1:0]     idx_reg, idx_next;
    attr_t             attr_reg, attr_next;
    logic [SW-1:0]     p_reg, p_next;
    logic [SW-1:0]     prev_reg, prev_next;
    logic              hasp_reg, hasp_next;
    logic              found_reg, found_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic [QW-1:0]     lidx_reg, lidx_next;
    logic [SW-1:0]     cur_reg, cur_next;
    logic              pend_reg, pend_next;
    logic [CW-1:0]     alive_reg, alive_next;
    logic [CW-1:0]     dcnt_reg, dcnt_next;
    logic [SW-1:0]     qhead_reg [PRIORITY_LEVELS];
    logic [SW-1:0]     qhead_next [PRIORITY_LEVELS];
    logic [SW-1:0]     qtail_reg [PRIORITY_LEVELS];
    logic [SW-1:0]     qtail_next [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] qocc_reg, qocc_next;
    rstat_t            rst_reg, rst_next;
    logic [SW-1:0]     asg_reg, asg_next;
    logic              sw_reg, sw_next;
    logic              idle_reg, idle_next;
    logic              done_reg, done_next;
    logic              mv_reg, mv_next;
    logic [OUT_W-1:0]  md_reg, md_next;

    // thread table ports
    logic              a_we;
    logic [SW-1:0]     a_waddr;
    attr_t             a_wdata;
    logic [SW-1:0]     a_raddr;
    attr_t             a_rdata;
    logic              n_we;
    logic [SW-1:0]     n_waddr;
    logic [SW-1:0]     n_wdata;
    logic [SW-1:0]     n_raddr;
    logic [SW-1:0]     n_rdata;

    // helpers
    logic [LVL_W-1:0]  prio_in;
    logic [8:0]        slot_w;
    logic [8:0]        asg_w;
    logic [8:0]        cur_w;
    logic [QW-1:0]     qa;
    logic [QW-1:0]     qr;
    attr_t             wa;
    logic [CW-1:0]     alive_d;
    logic [CW-1:0]     dcnt_d;
    logic              is_tail;

    pfts_ttab #(
        .THREAD_SLOTS (THREAD_SLOTS),
        .MAIN_LVL     (MAIN_LVL),
        .SW           (SW)
    ) u_ttab (
        .clk     (clk),
        .rst_n   (rst_n),
        .a_we    (a_we),
        .a_waddr (a_waddr),
        .a_wdata (a_wdata),
        .a_raddr (a_raddr),
        .a_rdata (a_rdata),
        .n_we    (n_we),
        .n_waddr (n_waddr),
        .n_wdata (n_wdata),
        .n_raddr (n_raddr),
        .n_rdata (n_rdata)
    );

    // input field decode and priority clamp
    assign slot_w = 9'(s_tdata[7:3]);
    always_comb
    begin
        prio_in = LVL_W'(s_tdata[11:8]);
        if (prio_in == '0)
        begin
            prio_in = LVL_W'(1);
        end
        else if (prio_in > LVL_W'(PRIORITY_LEVELS))
        begin
            prio_in = LVL_W'(PRIORITY_LEVELS);
        end
    end

    assign qa       = QW'(attr_reg.lvl - LVL_W'(1));
    assign qr       = QW'(a_rdata.lvl - LVL_W'(1));
    assign asg_w    = 9'(asg_reg);
    assign cur_w    = 9'(cur_reg);
    assign is_tail  = (p_reg == qtail_reg[qa]);
    assign alive_d  = (alive_reg != '0) ? alive_reg - CW'(1) : alive_reg;
    assign dcnt_d   = (a_rdata.dmn && dcnt_reg != '0) ? dcnt_reg - CW'(1) : dcnt_reg;
    assign s_tready = (state_reg == SQ_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    // sequencer: next state and datapath
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        s_next     = s_reg;
        sok_next   = sok_reg;
        prio_next  = prio_reg;
        dmn_next   = dmn_reg;
        idx_next   = idx_reg;
        attr_next  = attr_reg;
        p_next     = p_reg;
        prev_next  = prev_reg;
        hasp_next  = hasp_reg;
        found_next = found_reg;
        steps_next = steps_reg;
        lidx_next  = lidx_reg;
        cur_next   = cur_reg;
        pend_next  = pend_reg;
        alive_next = alive_reg;
        dcnt_next  = dcnt_reg;
        qhead_next = qhead_reg;
        qtail_next = qtail_reg;
        qocc_next  = qocc_reg;
        rst_next   = rst_reg;
        asg_next   = asg_reg;
        sw_next    = sw_reg;
        idle_next  = idle_reg;
        done_next  = done_reg;
        mv_next    = mv_reg;
        md_next    = md_reg;
        a_we       = 1'b0;
        a_waddr    = s_reg;
        a_wdata    = attr_reg;
        a_raddr    = s_reg;
        n_we       = 1'b0;
        n_waddr    = p_reg;
        n_wdata    = s_reg;
        n_raddr    = p_reg;
        wa         = a_rdata;

        // output register drains independently
        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            SQ_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = cmd_t'(s_tdata[2:0]);
                    s_next     = slot_w[SW-1:0];
                    sok_next   = (slot_w < 9'(THREAD_SLOTS));
                    prio_next  = prio_in;
                    dmn_next   = s_tdata[12];
                    state_next = SQ_DISPATCH;
                end
            end

            SQ_DISPATCH:
            begin
                rst_next  = RS_NOCHG;
                asg_next  = '0;
                sw_next   = 1'b0;
                idle_next = 1'b0;
                done_next = 1'b0;
                unique case (cmd_reg)
                    CMD_START:
                    begin
                        idx_next   = '0;
                        state_next = SQ_SCAN_RD;
                    end
                    CMD_RESCHED:
                    begin
                        pend_next  = 1'b0;
                        rst_next   = RS_DONE;
                        lidx_next  = QW'(PRIORITY_LEVELS - 1);
                        state_next = SQ_PICK;
                    end
                    CMD_YIELD:
                    begin
                        state_next = SQ_ATTR_RD;
                    end
                    default:
                    begin
                        state_next = sok_reg ? SQ_ATTR_RD : SQ_FINISH;
                    end
                endcase
            end

            // lowest free slot search
            SQ_SCAN_RD:
            begin
                a_raddr    = idx_reg[SW-1:0];
                state_next = SQ_SCAN_CHK;
            end

            SQ_SCAN_CHK:
            begin
                if (a_rdata.st == TS_FREE)
                begin
                    wa.st      = TS_RUN;
                    wa.lvl     = prio_reg;
                    wa.usr     = 1'b0;
                    wa.dmn     = dmn_reg;
                    a_we       = 1'b1;
                    a_waddr    = idx_reg[SW-1:0];
                    a_wdata    = wa;
                    attr_next  = wa;
                    s_next     = idx_reg[SW-1:0];
                    asg_next   = idx_reg[SW-1:0];
                    alive_next = alive_reg + CW'(1);
                    dcnt_next  = dmn_reg ? dcnt_reg + CW'(1) : dcnt_reg;
                    rst_next   = RS_DONE;
                    state_next = SQ_AP_RD;
                end
                else if (idx_reg == CW'(THREAD_SLOTS - 1))
                begin
                    rst_next   = RS_FULL;
                    state_next = SQ_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = SQ_SCAN_RD;
                end
            end

            SQ_ATTR_RD:
            begin
                a_raddr    = (cmd_reg == CMD_YIELD) ? cur_reg : s_reg;
                state_next = SQ_DECIDE;
            end

            // per-command checks on the slot attributes
            SQ_DECIDE:
            begin
                attr_next  = a_rdata;
                state_next = SQ_FINISH;
                unique case (cmd_reg)
                    CMD_RESUME, CMD_URESUME:
                    begin
                        if (cmd_reg == CMD_URESUME && a_rdata.usr)
                        begin
                            wa.usr   = 1'b0;
                            rst_next = RS_DONE;
                            a_we     = 1'b1;
                        end
                        if ((cmd_reg == CMD_RESUME || a_rdata.usr) && a_rdata.st == TS_SUSP)
                        begin
                            wa.st      = TS_RUN;
                            rst_next   = RS_DONE;
                            a_we       = 1'b1;
                            state_next = SQ_AP_RD;
                        end
                        a_wdata   = wa;
                        attr_next = wa;
                    end
                    CMD_SUSPEND:
                    begin
                        if (a_rdata.st == TS_RUN)
                        begin
                            wa.st      = TS_SUSP;
                            wa.usr     = 1'b1;
                            a_we       = 1'b1;
                            a_wdata    = wa;
                            attr_next  = wa;
                            rst_next   = RS_DONE;
                            state_next = SQ_UL_INIT;
                        end
                    end
                    CMD_KILL:
                    begin
                        if (a_rdata.st == TS_RUN || a_rdata.st == TS_SUSP)
                        begin
                            wa.st      = (s_reg == SW'(MAIN_SLOT)) ? TS_DEAD : TS_FREE;
                            wa.usr     = 1'b0;
                            wa.dmn     = 1'b0;
                            a_we       = 1'b1;
                            a_wdata    = wa;
                            attr_next  = wa;
                            alive_next = alive_d;
                            dcnt_next  = dcnt_d;
                            done_next  = (alive_d == dcnt_d);
                            pend_next  = 1'b1;
                            rst_next   = RS_DONE;
                            if (a_rdata.st == TS_RUN)
                            begin
                                state_next = SQ_UL_INIT;
                            end
                        end
                    end
                    CMD_YIELD:
                    begin
                        if (a_rdata.st == TS_RUN && qocc_reg[qr] && qhead_reg[qr] == cur_reg
                            && qtail_reg[qr] != cur_reg)
                        begin
                            n_raddr    = cur_reg;
                            state_next = SQ_Y_NEXT;
                        end
                    end
                    CMD_SETPRIO:
                    begin
                        if (a_rdata.st == TS_SUSP)
                        begin
                            wa.lvl    = prio_reg;
                            a_we      = 1'b1;
                            a_wdata   = wa;
                            attr_next = wa;
                            rst_next  = RS_DONE;
                        end
                        else if (a_rdata.st == TS_RUN)
                        begin
                            rst_next   = RS_DONE;
                            state_next = SQ_UL_INIT;
                        end
                    end
                    default:
                    begin
                        state_next = SQ_FINISH;
                    end
                endcase
            end

            // queue unlink walk
            SQ_UL_INIT:
            begin
                if (qocc_reg[qa])
                begin
                    p_next     = qhead_reg[qa];
                    hasp_next  = 1'b0;
                    steps_next = '0;
                    state_next = SQ_UL_CHK;
                end
                else
                begin
                    state_next = SQ_AFTER_UL;
                end
            end

            SQ_UL_CHK:
            begin
                n_raddr = p_reg;
                priority if (CW'(p_reg) >= CW'(THREAD_SLOTS))
                begin
                    state_next = SQ_AFTER_UL;
                end
                else if (p_reg == s_reg)
                begin
                    if (is_tail)
                    begin
                        if (hasp_reg)
                        begin
                            qtail_next[qa] = prev_reg;
                        end
                        else
                        begin
                            qocc_next[qa] = 1'b0;
                        end
                        state_next = SQ_AFTER_UL;
                    end
                    else
                    begin
                        found_next = 1'b1;
                        state_next = SQ_UL_NXT;
                    end
                end
                else if (is_tail)
                begin
                    state_next = SQ_AFTER_UL;
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = SQ_UL_NXT;
                end
            end

            SQ_UL_NXT:
            begin
                if (found_reg)
                begin
                    if (hasp_reg)
                    begin
                        n_we    = 1'b1;
                        n_waddr = prev_reg;
                        n_wdata = n_rdata;
                    end
                    else
                    begin
                        qhead_next[qa] = n_rdata;
                    end
                    state_next = SQ_AFTER_UL;
                end
                else
                begin
                    prev_next  = p_reg;
                    hasp_next  = 1'b1;
                    p_next     = n_rdata;
                    steps_next = steps_reg + CW'(1);
                    state_next = (steps_reg == CW'(THREAD_SLOTS - 1)) ? SQ_AFTER_UL : SQ_UL_CHK;
                end
            end

            SQ_AFTER_UL:
            begin
                state_next = SQ_FINISH;
                if (cmd_reg == CMD_SETPRIO)
                begin
                    state_next = SQ_SET_LVL;
                end
                else if (cmd_reg == CMD_SUSPEND && s_reg == cur_reg)
                begin
                    pend_next  = 1'b0;
                    lidx_next  = QW'(PRIORITY_LEVELS - 1);
                    state_next = SQ_PICK;
                end
            end

            SQ_SET_LVL:
            begin
                wa         = attr_reg;
                wa.lvl     = prio_reg;
                a_we       = 1'b1;
                a_wdata    = wa;
                attr_next  = wa;
                state_next = SQ_AP_RD;
            end

            // append at queue tail; current level read for the preempt check
            SQ_AP_RD:
            begin
                a_raddr    = cur_reg;
                state_next = SQ_AP_DO;
            end

            SQ_AP_DO:
            begin
                if (!qocc_reg[qa])
                begin
                    qhead_next[qa] = s_reg;
                    qtail_next[qa] = s_reg;
                    qocc_next[qa]  = 1'b1;
                    if (attr_reg.lvl > a_rdata.lvl)
                    begin
                        pend_next = 1'b1;
                    end
                end
                else
                begin
                    n_we           = 1'b1;
                    n_waddr        = qtail_reg[qa];
                    n_wdata        = s_reg;
                    qtail_next[qa] = s_reg;
                end
                state_next = SQ_FINISH;
            end

            // yield: rotate head to tail
            SQ_Y_NEXT:
            begin
                qhead_next[qa] = n_rdata;
                n_we           = 1'b1;
                n_waddr        = qtail_reg[qa];
                n_wdata        = cur_reg;
                qtail_next[qa] = cur_reg;
                pend_next      = 1'b1;
                rst_next       = RS_DONE;
                state_next     = SQ_FINISH;
            end

            // highest non-empty level, one level per cycle
            SQ_PICK:
            begin
                if (qocc_reg[lidx_reg])
                begin
                    if (qhead_reg[lidx_reg] != cur_reg)
                    begin
                        cur_next = qhead_reg[lidx_reg];
                        sw_next  = 1'b1;
                    end
                    state_next = SQ_FINISH;
                end
                else if (lidx_reg == '0)
                begin
                    idle_next  = 1'b1;
                    state_next = SQ_FINISH;
                end
                else
                begin
                    lidx_next = lidx_reg - QW'(1);
                end
            end

            SQ_FINISH:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    md_next    = {done_reg, idle_reg, pend_reg, sw_reg, cur_w[4:0],
                                  asg_w[4:0], rst_reg};
                    state_next = SQ_IDLE;
                end
            end

            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    // control and queue registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            cur_reg   <= SW'(MAIN_SLOT);
            pend_reg  <= 1'b0;
            alive_reg <= CW'(1);
            dcnt_reg  <= '0;
            qocc_reg  <= PRIORITY_LEVELS'(1) << (MAIN_LVL - 1);
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                qhead_reg[i] <= SW'(MAIN_SLOT);
                qtail_reg[i] <= SW'(MAIN_SLOT);
            end
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            pend_reg  <= pend_next;
            alive_reg <= alive_next;
            dcnt_reg  <= dcnt_next;
            qocc_reg  <= qocc_next;
            qhead_reg <= qhead_next;
            qtail_reg <= qtail_next;
            mv_reg    <= mv_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        s_reg     <= s_next;
        sok_reg   <= sok_next;
        prio_reg  <= prio_next;
        dmn_reg   <= dmn_next;
        idx_reg   <= idx_next;
        attr_reg  <= attr_next;
        p_reg     <= p_next;
        prev_reg  <= prev_next;
        hasp_reg  <= hasp_next;
        found_reg <= found_next;
        steps_reg <= steps_next;
        lidx_reg  <= lidx_next;
        rst_reg   <= rst_next;
        asg_reg   <= asg_next;
        sw_reg    <= sw_next;
        idle_reg  <= idle_next;
        done_reg  <= done_next;
        md_reg    <= md_next;
    end

    // daemon threads are a subset of living threads
    a_dcnt_le_alive: assert property (@(posedge clk) disable iff (!rst_n)
        dcnt_reg <= alive_reg)
        else $error("daemon count exceeds alive count");

    // living threads never exceed the slot pool
    a_alive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        alive_reg <= CW'(THREAD_SLOTS))
        else $error("alive count exceeds slot count");

    // current thread always names a real slot
    a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(cur_reg) < CW'(THREAD_SLOTS))
        else $error("current thread out of range");

    // a finished command presents its result next cycle once the output register is free
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_FINISH && (!mv_reg || m_tready)) |=> (mv_reg && state_reg == SQ_IDLE))
        else $error("result not presented after finish");

endmodule
`default_nettype wire

// ===== tb/tb_priority_fifo_thread_scheduler_core.sv =====
// testbench for the priority fifo thread scheduler core: directed and random command streams
`timescale 1ns / 1ps
`default_nettype none

// scoreboard: mirror of the scheduler state plus a queue of predicted results
class sched_scoreboard;
    localparam int NSLOT = 32;
    localparam int NLVL  = 10;

    pfts_pkg::tstate_t st[NSLOT];
    logic [3:0]        lvl[NSLOT];
    logic [4:0]        nxt[NSLOT];
    bit                usr[NSLOT];
    bit                dmn[NSLOT];
    logic [4:0]        qhead[NLVL];
    logic [4:0]        qtail[NLVL];
    bit                qocc[NLVL];
    logic [4:0]        cur;
    bit                pend;
    int                alive;
    int                daemons;
    logic [15:0]       expected_q[$];
    int                errors;
    int                checked;
    int                switches;
    int                idles;
    int                dones;
    int                fulls;

    function new();
        errors   = 0;
        checked  = 0;
        switches = 0;
        idles    = 0;
        dones    = 0;
        fulls    = 0;
        for (int i = 0; i < NSLOT; i++)
        begin
            st[i]  = pfts_pkg::TS_FREE;
            lvl[i] = 4'd1;
            nxt[i] = '0;
            usr[i] = 0;
            dmn[i] = 0;
        end
        for (int l = 0; l < NLVL; l++)
        begin
            qhead[l] = '0;
            qtail[l] = '0;
            qocc[l]  = 0;
        end
        st[0]    = pfts_pkg::TS_RUN;
        lvl[0]   = 4'd5;
        qocc[4]  = 1;
        cur      = '0;
        pend     = 0;
        alive    = 1;
        daemons  = 0;
    endfunction

    function logic [3:0] clamp_level(logic [3:0] p);
        if (p < 1) return 4'd1;
        if (p > NLVL) return 4'(NLVL);
        return p;
    endfunction

    // append a slot to the tail of its level
    function void link_tail(int s);
        int q;
        q = lvl[s] - 1;
        if (!qocc[q])
        begin
            qhead[q] = 5'(s);
            qtail[q] = 5'(s);
            qocc[q]  = 1;
            if (lvl[s] > lvl[cur]) pend = 1;
        end
        else
        begin
            nxt[qtail[q]] = 5'(s);
            qtail[q] = 5'(s);
        end
        nxt[s] = '0;
    endfunction

    // remove a slot from its level list
    function void unlink(int s);
        int  q;
        int  p;
        int  prev;
        bit  has_prev;
        bit  is_tail;
        q = lvl[s] - 1;
        prev = 0;
        has_prev = 0;
        if (!qocc[q]) return;
        p = qhead[q];
        for (int k = 0; k < NSLOT; k++)
        begin
            is_tail = (p == qtail[q]);
            if (p == s)
            begin
                if (is_tail)
                begin
                    if (has_prev) qtail[q] = 5'(prev);
                    else qocc[q] = 0;
                end
                else if (has_prev) nxt[prev] = nxt[p];
                else qhead[q] = nxt[p];
                return;
            end
            if (is_tail) return;
            prev = p;
            has_prev = 1;
            p = nxt[p];
        end
    endfunction

    // select head of highest non-empty level
    function void pick(ref bit sw, ref bit idl);
        pend = 0;
        for (int l = NLVL - 1; l >= 0; l--)
        begin
            if (qocc[l])
            begin
                if (qhead[l] != cur)
                begin
                    cur = qhead[l];
                    sw  = 1;
                end
                return;
            end
        end
        idl = 1;
    endfunction

    // note an accepted command and queue its predicted result
    function void note_command(pfts_pkg::cmd_t cmd, logic [4:0] s, logic [3:0] preq, bit isd);
        pfts_pkg::rstat_t stat;
        logic [4:0]       asg;
        bit               sw;
        bit               idl;
        bit               done;
        logic [3:0]       pr;
        int               c;
        int               q;
        stat = pfts_pkg::RS_NOCHG;
        asg  = '0;
        sw   = 0;
        idl  = 0;
        done = 0;
        pr   = clamp_level(preq);
        case (cmd)
            pfts_pkg::CMD_START:
            begin
                stat = pfts_pkg::RS_FULL;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (st[i] == pfts_pkg::TS_FREE)
                    begin
                        st[i]  = pfts_pkg::TS_RUN;
                        lvl[i] = pr;
                        usr[i] = 0;
                        dmn[i] = isd;
                        alive++;
                        if (isd) daemons++;
                        link_tail(i);
                        stat = pfts_pkg::RS_DONE;
                        asg  = 5'(i);
                        break;
                    end
                end
            end
            pfts_pkg::CMD_RESUME, pfts_pkg::CMD_URESUME:
            begin
                // user resume needs the user suspend mark
                if (cmd != pfts_pkg::CMD_URESUME || usr[s])
                begin
                    if (cmd == pfts_pkg::CMD_URESUME)
                    begin
                        usr[s] = 0;
                        stat = pfts_pkg::RS_DONE;
                    end
                    if (st[s] == pfts_pkg::TS_SUSP)
                    begin
                        st[s] = pfts_pkg::TS_RUN;
                        link_tail(s);
                        stat = pfts_pkg::RS_DONE;
                    end
                end
            end
            pfts_pkg::CMD_SUSPEND:
            begin
                if (st[s] == pfts_pkg::TS_RUN)
                begin
                    st[s]  = pfts_pkg::TS_SUSP;
                    usr[s] = 1;
                    unlink(s);
                    if (s == cur) pick(sw, idl);
                    stat = pfts_pkg::RS_DONE;
                end
            end
            pfts_pkg::CMD_KILL:
            begin
                if (st[s] == pfts_pkg::TS_RUN || st[s] == pfts_pkg::TS_SUSP)
                begin
                    if (st[s] == pfts_pkg::TS_RUN) unlink(s);
                    st[s] = pfts_pkg::TS_DEAD;
                    if (alive > 0) alive--;
                    if (dmn[s] && daemons > 0) daemons--;
                    if (alive == daemons) done = 1;
                    usr[s] = 0;
                    dmn[s] = 0;
                    if (s != 0) st[s] = pfts_pkg::TS_FREE;
                    pend = 1;
                    stat = pfts_pkg::RS_DONE;
                end
            end
            pfts_pkg::CMD_YIELD:
            begin
                c = cur;
                q = lvl[c] - 1;
                if (st[c] == pfts_pkg::TS_RUN && qocc[q] && qhead[q] == c && qtail[q] != c)
                begin
                    qhead[q] = nxt[c];
                    nxt[qtail[q]] = 5'(c);
                    qtail[q] = 5'(c);
                    nxt[c] = '0;
                    pend = 1;
                    stat = pfts_pkg::RS_DONE;
                end
            end
            pfts_pkg::CMD_SETPRIO:
            begin
                if (st[s] == pfts_pkg::TS_SUSP)
                begin
                    lvl[s] = pr;
                    stat = pfts_pkg::RS_DONE;
                end
                else if (st[s] == pfts_pkg::TS_RUN)
                begin
                    unlink(s);
                    lvl[s] = pr;
                    link_tail(s);
                    stat = pfts_pkg::RS_DONE;
                end
            end
            default:
            begin
                pick(sw, idl);
                stat = pfts_pkg::RS_DONE;
            end
        endcase
        if (stat == pfts_pkg::RS_FULL) fulls++;
        switches += sw;
        idles    += idl;
        dones    += done;
        expected_q.push_back({done, idl, pend, sw, cur, asg, stat});
    endfunction

    function void cmp(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // compare one result transaction with the oldest prediction
    function void check_result(logic [15:0] got);
        logic [15:0] want;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result transaction 0x%04h", got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        cmp("status", want[1:0], got[1:0]);
        cmp("assigned_slot", want[6:2], got[6:2]);
        cmp("running_slot", want[11:7], got[11:7]);
        cmp("switched", want[12], got[12]);
        cmp("resched_pending", want[13], got[13]);
        cmp("idle", want[14], got[14]);
        cmp("all_done", want[15], got[15]);
    endfunction
endclass

module tb_priority_fifo_thread_scheduler_core;
    import pfts_pkg::*;

    localparam int LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    sched_scoreboard sb;
    bit              quiet;
    int              cycles;

    priority_fifo_thread_scheduler_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    // result side: random back-pressure, check on rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    initial
    begin
        int n;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                m_tready = 0;
                repeat (n) @(negedge clk);
            end
            m_tready = 1;
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // send one command transaction, with an optional idle burst ahead
    task automatic send_cmd(cmd_t cmd, logic [4:0] s, logic [3:0] pr, bit isd);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tdata  = {3'b0, isd, pr, s, cmd};
        s_tvalid = 1;
        do @(posedge clk); while (!s_tready);
        sb.note_command(cmd, s, pr, isd);
        @(negedge clk);
        s_tvalid = 0;
    endtask

    // random slot biased toward live threads
    function automatic logic [4:0] pick_slot();
        int tries;
        logic [4:0] s;
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        for (tries = 0; tries < 8; tries++)
        begin
            s = 5'($urandom_range(0, 31));
            if (sb.st[s] != TS_FREE) return s;
        end
        return s;
    endfunction

    initial
    begin
        cmd_t c;
        sb = new();
        cycles = 0;
        quiet = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: every command, priority extremes, corner cases
        send_cmd(CMD_RESCHED, 5'd0, 4'd0, 0);
        send_cmd(CMD_YIELD, 5'd0, 4'd0, 0);
        send_cmd(CMD_START, 5'd31, 4'd0, 0);
        send_cmd(CMD_START, 5'd0, 4'd15, 1);
        send_cmd(CMD_START, 5'd0, 4'd10, 0);
        send_cmd(CMD_START, 5'd0, 4'd5, 1);
        send_cmd(CMD_RESCHED, 5'd0, 4'd0, 0);
        send_cmd(CMD_YIELD, 5'd0, 4'd0, 0);
        send_cmd(CMD_RESCHED, 5'd0, 4'd0, 0);
        send_cmd(CMD_RESUME, 5'd1, 4'd0, 0);
        send_cmd(CMD_URESUME, 5'd1, 4'd0, 0);
        send_cmd(CMD_SUSPEND, 5'd2, 4'd0, 0);
        send_cmd(CMD_SETPRIO, 5'd2, 4'd1, 0);
        send_cmd(CMD_URESUME, 5'd2, 4'd0, 0);
        send_cmd(CMD_SETPRIO, 5'd3, 4'd9, 0);
        send_cmd(CMD_SUSPEND, 5'd31, 4'd0, 0);
        send_cmd(CMD_KILL, 5'd30, 4'd0, 0);
        send_cmd(CMD_SETPRIO, 5'd30, 4'd3, 0);
        send_cmd(CMD_KILL, 5'd3, 4'd0, 0);
        send_cmd(CMD_KILL, 5'd0, 4'd0, 0);
        send_cmd(CMD_KILL, 5'd0, 4'd0, 0);
        send_cmd(CMD_KILL, 5'd2, 4'd0, 0);
        send_cmd(CMD_RESCHED, 5'd0, 4'd0, 0);
        // fill every slot to reach the full case
        for (int i = 0; i < 33; i++)
            send_cmd(CMD_START, 5'($urandom), 4'($urandom), 1'($urandom));

        // random mix, mostly on live slots
        for (int i = 0; i < 420; i++)
        begin
            if (i == 380) quiet = 1;
            c = cmd_t'($urandom_range(0, 7));
            send_cmd(c, pick_slot(), 4'($urandom), 1'($urandom));
        end

        // drain
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("checked %0d results: %0d switches, %0d idle, %0d all_done, %0d full",
                 sb.checked, sb.switches, sb.idles, sb.dones, sb.fulls);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
